// ----- design/pps_pkg.sv -----
package pps_pkg;

	// Pattern storage and field widths.
	localparam int PATTERN_DEPTH = 8;
	localparam int DURATION_BITS = 16;
	localparam int SLOT_W        = 16;
	localparam int SLOT_COUNT    = 8;
	localparam int STEP_W        = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int LEN_W         = 4;
	localparam int ELAPSED_W     = 16;
	localparam int JUMP_W        = 16;
	localparam int ACCUM_W       = 17;
	localparam int RUN_W         = 32;

	localparam logic [ACCUM_W-1:0] ACCUM_MAX = '1;
	localparam logic [RUN_W-1:0]   RUN_LOOP  = '1;
	localparam logic [LEN_W-1:0]   USED_MAX  = LEN_W'(PATTERN_DEPTH);

	// Configuration port.
	localparam int DATA_W  = 64;
	localparam int REG_LSB = 3;
	localparam int ADDR_W  = 6;

	localparam logic [JUMP_W-1:0] JUMP_RESET = JUMP_W'(500);

	typedef enum logic [ADDR_W-REG_LSB-1:0] {
		REG_DUR_LOW    = 3'd0,
		REG_DUR_HIGH   = 3'd1,
		REG_PAT_LEN    = 3'd2,
		REG_START_LVL  = 3'd3,
		REG_END_LVL    = 3'd4,
		REG_JUMP_LIMIT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_TICK       = 2'd0,
		KIND_START_ONCE = 2'd1,
		KIND_START_LOOP = 2'd2,
		KIND_STOP       = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic pin_level;
		logic pin_written;
		logic running;
		logic stop_status;
	} out_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] durations_low;
		logic [DATA_W-1:0] durations_high;
		logic [LEN_W-1:0]  pattern_length;
		logic              start_level;
		logic              end_level;
		logic [JUMP_W-1:0] jump_limit_ms;
	} cfg_t;

endpackage

// ----- design/pps_regs.sv -----
module pps_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pps_pkg::ADDR_W-1:0] paddr,
	input  logic [pps_pkg::DATA_W-1:0] pwdata,
	output logic [pps_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output pps_pkg::cfg_t               cfg
);
	import pps_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel_idx;
	logic     wr_en;

	assign sel_idx = reg_idx_t'(paddr[ADDR_W-1:REG_LSB]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.durations_low  <= '0;
			cfg_q.durations_high <= '0;
			cfg_q.pattern_length <= LEN_W'(1);
			cfg_q.start_level    <= 1'b1;
			cfg_q.end_level      <= 1'b0;
			cfg_q.jump_limit_ms  <= JUMP_RESET;
		end else if (wr_en) begin
			unique case (sel_idx)
				REG_DUR_LOW:    cfg_q.durations_low  <= pwdata;
				REG_DUR_HIGH:   cfg_q.durations_high <= pwdata;
				REG_PAT_LEN:    cfg_q.pattern_length <= pwdata[LEN_W-1:0];
				REG_START_LVL:  cfg_q.start_level    <= pwdata[0];
				REG_END_LVL:    cfg_q.end_level      <= pwdata[0];
				REG_JUMP_LIMIT: cfg_q.jump_limit_ms  <= pwdata[JUMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel_idx)
			REG_DUR_LOW:    prdata = cfg_q.durations_low;
			REG_DUR_HIGH:   prdata = cfg_q.durations_high;
			REG_PAT_LEN:    prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_q.pattern_length};
			REG_START_LVL:  prdata = {{(DATA_W-1){1'b0}}, cfg_q.start_level};
			REG_END_LVL:    prdata = {{(DATA_W-1){1'b0}}, cfg_q.end_level};
			REG_JUMP_LIMIT: prdata = {{(DATA_W-JUMP_W){1'b0}}, cfg_q.jump_limit_ms};
			default:        prdata = '0;
		endcase
	end

endmodule

// ----- design/pps_engine.sv -----
module pps_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  pps_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  pps_pkg::in_item_t  in_data,
	input  logic               full,
	output logic               push,
	output pps_pkg::out_item_t push_data
);
	import pps_pkg::*;

	// Input register.
	logic     valid_s1;
	in_item_t item_s1;
	logic     adv;

	// Pattern state.
	logic [RUN_W-1:0]   run_count_q, run_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic               await_q, await_d;
	logic [ACCUM_W-1:0] accum_q, accum_d;
	logic               pin_q, pin_d;

	logic                     written, status;
	logic [SLOT_COUNT-1:0][SLOT_W-1:0] slots;
	logic [DURATION_BITS-1:0] dur;
	logic [ACCUM_W:0]         sum;
	logic [ACCUM_W-1:0]       acc_sat;
	logic [ACCUM_W-1:0]       acc_left;
	logic [STEP_W:0]          next_step;
	logic [LEN_W-1:0]         used_len;
	logic [RUN_W-1:0]         run_dec;
	logic                     tick_ok;

	assign adv      = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;
	assign push     = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Datapath terms shared by the tick arm.
	assign slots     = {cfg.durations_high, cfg.durations_low};
	assign dur       = slots[step_q][DURATION_BITS-1:0];
	assign sum       = {1'b0, accum_q} + (ACCUM_W+1)'(item_s1.elapsed_ms);
	assign acc_sat   = sum[ACCUM_W] ? ACCUM_MAX : sum[ACCUM_W-1:0];
	assign acc_left  = acc_sat - ACCUM_W'(dur);
	assign next_step = {1'b0, step_q} + (STEP_W+1)'(1);
	assign run_dec   = (run_count_q != RUN_LOOP) ? run_count_q - RUN_W'(1) : run_count_q;
	assign tick_ok   = (item_s1.elapsed_ms <= cfg.jump_limit_ms) && (run_count_q != '0);

	always_comb begin
		if (cfg.pattern_length == '0) begin
			used_len = LEN_W'(1);
		end else if (cfg.pattern_length > USED_MAX) begin
			used_len = USED_MAX;
		end else begin
			used_len = cfg.pattern_length;
		end
	end

	always_comb begin
		run_d   = run_count_q;
		step_d  = step_q;
		await_d = await_q;
		accum_d = accum_q;
		pin_d   = pin_q;
		written = 1'b0;
		status  = 1'b0;
		unique case (item_s1.kind) inside
			KIND_TICK: begin
				if (tick_ok) begin
					if (await_q) begin
						await_d = 1'b0;
						step_d  = '0;
						accum_d = '0;
						pin_d   = cfg.start_level;
						written = 1'b1;
					end else begin
						accum_d = acc_sat;
						if (acc_sat >= ACCUM_W'(dur)) begin
							accum_d = acc_left;
							written = 1'b1;
							if (LEN_W'(next_step) < used_len) begin
								step_d = next_step[STEP_W-1:0];
								pin_d  = !pin_q;
							end else if (run_dec != '0) begin
								run_d  = run_dec;
								step_d = '0;
								pin_d  = cfg.start_level;
							end else begin
								run_d   = '0;
								step_d  = '0;
								await_d = 1'b1;
								accum_d = '0;
								pin_d   = cfg.end_level;
							end
						end
					end
				end
			end
			KIND_START_ONCE, KIND_START_LOOP: begin
				if (run_count_q != '0) begin
					if (run_count_q < RUN_LOOP - RUN_W'(1)) begin
						run_d = run_count_q + RUN_W'(1);
					end
				end else begin
					run_d   = RUN_W'(1);
					step_d  = '0;
					await_d = 1'b1;
					accum_d = '0;
				end
				if (item_s1.kind == KIND_START_LOOP) begin
					run_d = RUN_LOOP;
				end
			end
			KIND_STOP: begin
				if (run_count_q != '0) begin
					run_d   = '0;
					step_d  = '0;
					await_d = 1'b1;
					accum_d = '0;
					pin_d   = cfg.end_level;
					written = 1'b1;
				end else begin
					status = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= '0;
			step_q      <= '0;
			await_q     <= 1'b1;
			accum_q     <= '0;
			pin_q       <= 1'b0;
		end else if (adv) begin
			run_count_q <= run_d;
			step_q      <= step_d;
			await_q     <= await_d;
			accum_q     <= accum_d;
			pin_q       <= pin_d;
		end
	end

	assign push_data = '{
		pin_level:   pin_d,
		pin_written: written,
		running:     (run_d != '0),
		stop_status: status
	};

	// A pattern that has seen its first tick always has runs left.
	a_armed_has_runs: assert property (@(posedge clk) disable iff (!arst_n)
		!await_q |-> run_count_q != '0)
		else $error("pattern past first tick with zero run count");

	// While stopped, the step and time state are cleared.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		run_count_q == '0 |-> (step_q == '0 && accum_q == '0 && await_q))
		else $error("stopped pattern holds stale step or time state");

	// A stop item always leaves the pattern stopped.
	a_stop_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.kind == KIND_STOP) |=> run_count_q == '0)
		else $error("pattern still running after a stop item");

	// The result queue is never written while full.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into a full queue");

endmodule

// ----- design/pps_out_queue.sv -----
module pps_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pps_pkg::out_item_t push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_ready,
	output pps_pkg::out_item_t out_data
);
	import pps_pkg::*;

	out_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- design/pin_pattern_sequencer_core.sv -----
// Pin pattern sequencer. Each input item is a tick carrying elapsed milliseconds, a
// start-once, a start-loop or a stop, and each item produces exactly one result item
// reporting the pin level, whether the pin was written, whether the pattern is still
// running, and, for stop items, whether the pattern was already stopped. The block
// accepts one item per clock cycle in steady state while the result queue has room: an
// item is captured in an input register, its whole state update (one saturating add, one
// duration compare and the run counter step) is done from that register against the
// pattern state registers once the queue can take the result, and the result goes into
// a two-entry result queue, from which it is offered to the consumer. Input ready
// depends only on registered state,
// so a stalled consumer never forms a combinational path back to the producer; with
// the queue full and an item waiting in the input register, input ready drops until
// the consumer takes a result. Configuration is written through the APB-style port at
// byte address 8 times the register index and should only change while no item is in
// flight. After reset the registers hold their documented defaults (one step, start
// level high, end level low, jump limit 500 ms) and the pin reads low until driven.
module pin_pattern_sequencer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  pps_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output pps_pkg::out_item_t          out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pps_pkg::ADDR_W-1:0] paddr,
	input  logic [pps_pkg::DATA_W-1:0] pwdata,
	output logic [pps_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import pps_pkg::*;

	cfg_t      cfg;
	logic      full;
	logic      push;
	out_item_t push_data;

	// Register file for pattern durations, length, levels and the jump limit.
	pps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register plus the pattern state update and its state registers.
	pps_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	// Result queue decoupling the consumer's ready from the input side.
	pps_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- tb/sv/tb_pin_pattern_sequencer_core.sv -----
`timescale 1ns / 1ps

module tb_pin_pattern_sequencer_core;
	import pps_pkg::*;

	// A generous cycle budget: roughly 2000 items, even with heavy idling on both sides,
	// need far less than this.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 244;
	localparam int REPORT_MAX   = 10;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_item_t            in_data  = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_item_t           out_data;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [ADDR_W-1:0]   paddr    = '0;
	logic [DATA_W-1:0]   pwdata   = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	pin_pattern_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Commands waiting to be offered, and pin reports predicted for accepted items.
	in_item_t  queued_commands[$];
	out_item_t expected_pin_reports[$];

	// Idle percentages of the sender and the receiver, changed between phases.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	// Set at each rising edge when the item on the input channel was taken.
	logic in_fire = 1'b0;

	int unsigned cycle_count   = 0;
	int unsigned failure_count = 0;
	int unsigned report_count  = 0;

	// Shadow copy of the configuration registers, starting at their reset values.
	cfg_t shadow_cfg = '{durations_low: '0, durations_high: '0, pattern_length: LEN_W'(1),
		start_level: 1'b1, end_level: 1'b0, jump_limit_ms: JUMP_RESET};

	// Shadow of the sequencer state.
	logic [RUN_W-1:0]   seq_run_count  = '0;
	logic [STEP_W-1:0]  seq_step       = '0;
	logic               seq_arming     = 1'b1;
	logic [ACCUM_W-1:0] seq_accum      = '0;
	logic               seq_pin        = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Drops the pattern and parks the pin at the end level.
	function automatic void park_pin();
		seq_run_count = '0;
		seq_step      = '0;
		seq_arming    = 1'b1;
		seq_accum     = '0;
		seq_pin       = shadow_cfg.end_level;
	endfunction

	// Applies one accepted command to the shadow state and returns the pin report
	// the block must produce for it.
	function automatic out_item_t advance_pattern(in_item_t cmd);
		out_item_t          rep;
		logic [DATA_W-1:0]  slot_word;
		logic [SLOT_W-1:0]  duration;
		logic [ACCUM_W:0]   sum;
		logic [LEN_W-1:0]   steps_used;
		logic [LEN_W-1:0]   next_step;
		rep = '0;
		case (cmd.kind) inside
			KIND_TICK: begin
				if (cmd.elapsed_ms <= shadow_cfg.jump_limit_ms && seq_run_count != '0) begin
					if (seq_arming) begin
						// First tick after a start drives the start level.
						seq_arming      = 1'b0;
						seq_step        = '0;
						seq_accum       = '0;
						seq_pin         = shadow_cfg.start_level;
						rep.pin_written = 1'b1;
					end else begin
						slot_word = seq_step[2] ? shadow_cfg.durations_high
							: shadow_cfg.durations_low;
						duration  = slot_word[seq_step[1:0]*SLOT_W +: SLOT_W];
						sum       = (ACCUM_W+1)'(seq_accum) + (ACCUM_W+1)'(cmd.elapsed_ms);
						// The accumulator sticks at all ones rather than wrapping.
						if (sum > (ACCUM_W+1)'(ACCUM_MAX))
							sum = (ACCUM_W+1)'(ACCUM_MAX);
						seq_accum = sum[ACCUM_W-1:0];
						if (sum >= (ACCUM_W+1)'(duration)) begin
							seq_accum  = ACCUM_W'(sum - (ACCUM_W+1)'(duration));
							steps_used = shadow_cfg.pattern_length;
							if (steps_used == '0)
								steps_used = LEN_W'(1);
							if (steps_used > USED_MAX)
								steps_used = USED_MAX;
							next_step = LEN_W'(seq_step) + LEN_W'(1);
							if (next_step < steps_used) begin
								seq_step = next_step[STEP_W-1:0];
								seq_pin  = ~seq_pin;
							end else begin
								// End of a pass: one run used up unless looping forever.
								if (seq_run_count != RUN_LOOP)
									seq_run_count = seq_run_count - RUN_W'(1);
								if (seq_run_count != '0) begin
									seq_step = '0;
									seq_pin  = shadow_cfg.start_level;
								end else begin
									park_pin();
								end
							end
							rep.pin_written = 1'b1;
						end
					end
				end
			end
			KIND_START_ONCE, KIND_START_LOOP: begin
				if (seq_run_count != '0) begin
					// Another start while running adds a run, holding below all ones.
					if (seq_run_count < RUN_LOOP - RUN_W'(1))
						seq_run_count = seq_run_count + RUN_W'(1);
				end else begin
					seq_run_count = RUN_W'(1);
					seq_step      = '0;
					seq_arming    = 1'b1;
					seq_accum     = '0;
				end
				if (cmd.kind == KIND_START_LOOP)
					seq_run_count = RUN_LOOP;
			end
			default: begin
				if (seq_run_count != '0) begin
					park_pin();
					rep.pin_written = 1'b1;
				end else begin
					rep.stop_status = 1'b1;
				end
			end
		endcase
		rep.pin_level = seq_pin;
		rep.running   = (seq_run_count != '0);
		return rep;
	endfunction

	// Prediction happens at the edge where the item is accepted, before the output
	// check of the same edge, so the order of reports always follows acceptance.
	always @(posedge clk) begin
		out_item_t want;
		in_fire <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_pin_reports.push_back(advance_pattern(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (expected_pin_reports.size() == 0) begin
				failure_count++;
				if (report_count < REPORT_MAX) begin
					report_count++;
					$display("unexpected result item: pin %b written %b running %b stop %b",
						out_data.pin_level, out_data.pin_written, out_data.running,
						out_data.stop_status);
				end
			end else begin
				want = expected_pin_reports.pop_front();
				if (out_data.pin_level !== want.pin_level
						|| out_data.pin_written !== want.pin_written
						|| out_data.running !== want.running
						|| out_data.stop_status !== want.stop_status) begin
					failure_count++;
					if (report_count < REPORT_MAX) begin
						report_count++;
						$display("mismatch: expected pin %b written %b running %b stop %b, %s",
							want.pin_level, want.pin_written, want.running, want.stop_status,
							$sformatf("got pin %b written %b running %b stop %b",
								out_data.pin_level, out_data.pin_written, out_data.running,
								out_data.stop_status));
					end
				end
			end
		end
	end

	// The driver works on the falling edge. A new item is only put up once the
	// previous one was taken, so valid and payload hold steady until acceptance.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= queued_commands.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// One register write over the configuration port: a setup phase, then an access
	// phase that completes at the edge where pready is seen high.
	task automatic write_register(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << REG_LSB;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DUR_LOW:    shadow_cfg.durations_low  = value;
			REG_DUR_HIGH:   shadow_cfg.durations_high = value;
			REG_PAT_LEN:    shadow_cfg.pattern_length = value[LEN_W-1:0];
			REG_START_LVL:  shadow_cfg.start_level    = value[0];
			REG_END_LVL:    shadow_cfg.end_level      = value[0];
			default:        shadow_cfg.jump_limit_ms  = value[JUMP_W-1:0];
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_all(logic [DATA_W-1:0] dur_low, logic [DATA_W-1:0] dur_high,
			logic [LEN_W-1:0] len, logic start_lvl, logic end_lvl,
			logic [JUMP_W-1:0] jump_limit);
		write_register(REG_DUR_LOW, dur_low);
		write_register(REG_DUR_HIGH, dur_high);
		write_register(REG_PAT_LEN, DATA_W'(len));
		write_register(REG_START_LVL, DATA_W'(start_lvl));
		write_register(REG_END_LVL, DATA_W'(end_lvl));
		write_register(REG_JUMP_LIMIT, DATA_W'(jump_limit));
	endtask

	// Waits until every queued item has been taken and every report has come back.
	task automatic wait_for_quiet();
		while (queued_commands.size() != 0 || in_valid || expected_pin_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic void queue_command(kind_t kind, logic [ELAPSED_W-1:0] elapsed);
		in_item_t cmd;
		cmd.kind       = kind;
		cmd.elapsed_ms = elapsed;
		queued_commands.push_back(cmd);
	endfunction

	// Four slots of short durations, so passes finish within a few ticks.
	function automatic logic [DATA_W-1:0] short_durations();
		logic [DATA_W-1:0] word;
		word = '0;
		for (int i = 0; i < 4; i++)
			word[i*SLOT_W +: SLOT_W] = SLOT_W'($urandom_range(0, 20));
		return word;
	endfunction

	// Mostly ticks of a few milliseconds, which walk the pattern through its steps,
	// with starts and stops sprinkled in. Some ticks sit on or just past the jump
	// limit or are fully random, so time jumps get exercised as well.
	function automatic in_item_t random_command();
		in_item_t    cmd;
		int unsigned pick;
		pick           = $urandom_range(99);
		cmd.elapsed_ms = ELAPSED_W'($urandom_range(0, 65535));
		if (pick < 72) begin
			cmd.kind = KIND_TICK;
			case ($urandom_range(9))
				7:       cmd.elapsed_ms = shadow_cfg.jump_limit_ms + JUMP_W'($urandom_range(1));
				8, 9:    ;
				default: cmd.elapsed_ms = ELAPSED_W'($urandom_range(0, 30));
			endcase
		end else if (pick < 86) begin
			cmd.kind = KIND_START_ONCE;
		end else if (pick < 90) begin
			cmd.kind = KIND_START_LOOP;
		end else begin
			cmd.kind = KIND_STOP;
		end
		return cmd;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset configuration: zero durations, one step,
		// start level high, end level low, jump limit 500 ms.
		send_idle_pct  = 10;
		recv_stall_pct = 10;
		queue_command(KIND_STOP, 16'h0000);        // stop while already stopped
		queue_command(KIND_TICK, 16'h0000);        // tick while stopped
		queue_command(KIND_START_ONCE, 16'hFFFF);
		queue_command(KIND_TICK, 16'hFFFF);        // time jump, ignored
		queue_command(KIND_TICK, 16'h0000);        // first tick drives the start level
		queue_command(KIND_START_ONCE, 16'h0000);  // second run added while running
		queue_command(KIND_TICK, 16'd500);         // pass ends, one run left
		queue_command(KIND_TICK, 16'd501);         // just over the jump limit
		queue_command(KIND_TICK, 16'd1);           // last run ends, end level
		queue_command(KIND_START_LOOP, 16'h0000);
		queue_command(KIND_START_ONCE, 16'h0000);  // count stays at loop forever
		queue_command(KIND_TICK, 16'h0000);
		queue_command(KIND_TICK, 16'd10);
		queue_command(KIND_STOP, 16'hFFFF);
		wait_for_quiet();

		// Zero durations with no jump limit let the accumulator run into saturation.
		write_all('0, '1, LEN_W'(1), 1'b0, 1'b1, 16'hFFFF);
		queue_command(KIND_START_LOOP, 16'h0000);
		queue_command(KIND_TICK, 16'h0000);
		queue_command(KIND_TICK, 16'hFFFF);
		queue_command(KIND_TICK, 16'hFFFF);
		queue_command(KIND_TICK, 16'hFFFF);
		queue_command(KIND_STOP, 16'h0000);
		wait_for_quiet();

		// Random phases, each with its own register setting and idling pattern.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: write_all(short_durations(), short_durations(), LEN_W'(4), 1'b1, 1'b0,
					16'd500);
				1: write_all(short_durations(), short_durations(), LEN_W'(8), 1'b0, 1'b1,
					16'hFFFF);
				2: write_all(short_durations(), short_durations(), LEN_W'(0), 1'b0, 1'b0,
					16'h0000);
				3: write_all('1, '1, LEN_W'(15), 1'b1, 1'b1, 16'hFFFF);
				4: write_all({$urandom, $urandom}, {$urandom, $urandom},
					LEN_W'($urandom_range(1, 8)), 1'($urandom), 1'($urandom), 16'hFFFF);
				default: write_all(short_durations(), short_durations(),
					LEN_W'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
					JUMP_W'($urandom_range(30, 65535)));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				queued_commands.push_back(random_command());
			wait_for_quiet();
		end

		// Let any stray late result show up before judging the run.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failure_count == 0 && expected_pin_reports.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/pps_pkg.sv
design/pps_regs.sv
design/pps_engine.sv
design/pps_out_queue.sv
design/pin_pattern_sequencer_core.sv
tb/sv/tb_pin_pattern_sequencer_core.sv
